### rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the periodic compare tick timer.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int CMP_W    = 32;
    localparam int TIME_W   = 64;
    localparam int FREQ_W   = 30;
    localparam int IVL_W    = 16;
    localparam int CMD_W    = 2;

    // Shift-add multiplier width, matches the 64-bit tick total
    localparam int MUL_W    = 64;

    // Derived clock ratios: freq/1000, freq/1e6 and (freq/1e6)*1000
    localparam int FK_W     = 21;
    localparam int PU_W     = 11;
    localparam int PMS_W    = 21;

    localparam int KILO     = 1000;
    localparam int MEGA     = 1000000;

    // Register reset values and the ratios that follow from them
    localparam int FREQ_RST = 100000000;
    localparam int IVL_RST  = 10;
    localparam int FK_RST   = FREQ_RST / KILO;
    localparam int PU_RST   = FREQ_RST / MEGA;
    localparam int PMS_RST  = PU_RST * KILO;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ     = 1'b0,
        REG_INTERVAL = 1'b1
    } t_cfg_reg;

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_START   = 2'd0,
        CMD_SERVICE = 2'd1,
        CMD_QRY_MS  = 2'd2,
        CMD_QRY_US  = 2'd3
    } t_cmd;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CFG_FK,
        ST_CFG_PU,
        ST_CFG_PMS,
        ST_START_W,
        ST_SV_PREP,
        ST_SV_CHK,
        ST_SV_DIV,
        ST_SV_MUL,
        ST_QRY_W,
        ST_QRY_US,
        ST_DONE
    } t_state;

    // One result item
    typedef struct packed {
        logic [CMP_W-1:0]  compare_value;
        logic              write_compare;
        logic              notify;
        logic              counter_enabled;
        logic [TIME_W-1:0] time_value;
    } t_result;

endpackage

### rtl/ptt_if.sv
// ----------------------------------------------------------------------------
// ptt_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface ptt_in_if
    import ptt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [SAMPLE_W-1:0] count_sample;

    modport source (output valid, command, count_sample, input ready);
    modport sink   (input valid, command, count_sample, output ready);
endinterface

interface ptt_out_if
    import ptt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMP_W-1:0]  compare_value;
    logic              write_compare;
    logic              notify;
    logic              counter_enabled;
    logic [TIME_W-1:0] time_value;

    modport source (output valid, compare_value, write_compare, notify,
                    counter_enabled, time_value, input ready);
    modport sink   (input valid, compare_value, write_compare, notify,
                    counter_enabled, time_value, output ready);
endinterface

### rtl/ptt_div.sv
// ----------------------------------------------------------------------------
// ptt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptt_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic [W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dvs;

    logic [W:0]       trial;
    logic [W:0]       diff;

    // Shift the next dividend bit into the remainder and try a subtract
    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: keep the remainder when the subtract borrows
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

### rtl/ptt_mul.sv
// ----------------------------------------------------------------------------
// ptt_mul
// Shift-add multiplier, one multiplier bit per cycle, product modulo 2^W.
// Stops as soon as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module ptt_mul #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_busy,
    output logic [W-1:0] o_product
);
    logic         r_busy;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;

    // Control: done once the multiplier has shifted out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_b == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // Datapath: add the shifted multiplicand for each set bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[W-2:0], 1'b0};
            r_b <= {1'b0, r_b[W-1:1]};
        end
    end

    assign o_busy    = r_busy;
    assign o_product = r_acc;

endmodule

### rtl/periodic_compare_tick_timer_top.sv
// ----------------------------------------------------------------------------
// periodic_compare_tick_timer_top
// Periodic tick timer on a free-running count: start, service, time queries.
// ----------------------------------------------------------------------------
// One item is worked on at a time; a new item is taken as soon as the
// sequencer is back in idle, even while the previous result still waits in
// the output register. All arithmetic beyond single adds runs on one bit-serial
// divider, DW = max(COUNT_WIDTH, 30) bits wide, and one shift-add multiplier.
// A start runs one multiplication; a service before start or one that lands
// within one interval needs neither unit; a late service runs one division
// and then one multiplication; a query runs a division and a multiplication
// side by side, and a microsecond query one more multiplication after them.
// A stalled result holds the sequencer in its last step. A write of
// counter_frequency_hz recomputes the counts per millisecond and microsecond
// on the same units, holding ready low until the recomputation is done.
// ----------------------------------------------------------------------------
module periodic_compare_tick_timer_top
    import ptt_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FREQ_W-1:0]    i_cfg_wdata,
    ptt_in_if.sink               i_in,
    ptt_out_if.source            o_out
);
    localparam int CW = COUNT_WIDTH;
    localparam int DW = (CW > FREQ_W) ? CW : FREQ_W;
    localparam logic [CW-1:0] HALF = {1'b1, {(CW - 1){1'b0}}};

    // State
    t_state             r_state, n_state;
    logic [FREQ_W-1:0]  r_freq, n_freq;
    logic [IVL_W-1:0]   r_interval, n_interval;
    logic [FK_W-1:0]    r_fk, n_fk;
    logic [PU_W-1:0]    r_pu, n_pu;
    logic [PMS_W-1:0]   r_pms, n_pms;
    logic [MUL_W-1:0]   r_tick, n_tick;
    logic [CW-1:0]      r_deadline, n_deadline;
    logic               r_running, n_running;
    logic [CW-1:0]      r_held, n_held;
    logic [IVL_W-1:0]   r_held_ms, n_held_ms;
    t_cmd               r_cmd, n_cmd;
    logic [CW-1:0]      r_now, n_now;
    logic [CW-1:0]      r_d, n_d;
    logic [CW-1:0]      r_extra, n_extra;
    t_result            r_res, n_res;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    // Arithmetic units
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [DW-1:0]      div_divisor;
    logic               div_busy;
    logic [DW-1:0]      div_quo;
    logic               mul_start;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic               mul_busy;
    logic [MUL_W-1:0]   mul_prod;

    // Single-step arithmetic, wrapped at the count width
    logic               in_acc;
    t_cmd               in_cmd;
    logic [CW-1:0]      in_now;
    logic [CW-1:0]      elapsed;
    logic [CW-1:0]      sv_nd;
    logic [CW-1:0]      sv_d;
    logic [CW-1:0]      sv_fwd;
    logic [CW-1:0]      sv_rev;
    logic [CW-1:0]      sv_back;
    logic [CW-1:0]      sv_extra;
    logic [CW-1:0]      mul_lo;
    logic [CW-1:0]      st_dl;
    logic [CW-1:0]      sv_dl;
    logic [MUL_W-1:0]   quo_ext;
    logic [MUL_W-1:0]   prod_sum;
    logic [PU_W-1:0]    pu_q;
    logic               sv_ahead;
    logic               sv_short;

    assign in_acc   = i_in.valid && i_in.ready;
    assign in_cmd   = t_cmd'(i_in.command);
    assign in_now   = CW'(i_in.count_sample);
    assign elapsed  = in_now - r_deadline + r_held;
    assign sv_nd    = r_deadline + r_held;
    assign sv_d     = r_now - sv_nd;
    assign sv_fwd   = r_d - CW'(1);
    assign sv_rev   = HALF - r_d - CW'(1);
    assign sv_back  = '0 - r_held;
    assign sv_extra = div_quo[CW-1:0] + CW'(1);
    assign mul_lo   = mul_prod[CW-1:0];
    assign st_dl    = r_now + mul_lo;
    assign sv_dl    = r_deadline + mul_lo;
    assign quo_ext  = MUL_W'(div_quo);
    assign prod_sum = mul_prod + quo_ext;
    assign pu_q     = (div_quo[PU_W-1:0] == '0) ? PU_W'(1) : div_quo[PU_W-1:0];
    assign sv_ahead = (r_d != '0) && !r_d[CW-1];
    assign sv_short = !r_held[CW-1] || (r_held == HALF);

    // Take items only from idle, never in the cycle of a register write
    assign i_in.ready = (r_state == ST_IDLE) && !i_cfg_we;

    ptt_div #(
        .W (DW)
    ) u_ptt_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    ptt_mul #(
        .W (MUL_W)
    ) u_ptt_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_busy    (mul_busy),
        .o_product (mul_prod)
    );

    // Sequencer: next state, unit launches and register updates
    always_comb begin
        n_state      = r_state;
        n_freq       = r_freq;
        n_interval   = r_interval;
        n_fk         = r_fk;
        n_pu         = r_pu;
        n_pms        = r_pms;
        n_tick       = r_tick;
        n_deadline   = r_deadline;
        n_running    = r_running;
        n_held       = r_held;
        n_held_ms    = r_held_ms;
        n_cmd        = r_cmd;
        n_now        = r_now;
        n_d          = r_d;
        n_extra      = r_extra;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;

        // Drop the result once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cmd = in_cmd;
                    n_now = in_now;
                    case (in_cmd)
                        CMD_START: begin
                            mul_start = 1'b1;
                            mul_a     = MUL_W'(r_fk);
                            mul_b     = MUL_W'(r_interval);
                            n_state   = ST_START_W;
                        end
                        CMD_SERVICE: begin
                            if (r_running) begin
                                n_state = ST_SV_PREP;
                            end else begin
                                n_res   = '0;
                                n_state = ST_DONE;
                            end
                        end
                        default: begin
                            // Queries: elapsed / divisor and ticks * interval
                            div_start    = 1'b1;
                            div_dividend = DW'(elapsed);
                            div_divisor  = (in_cmd == CMD_QRY_MS) ? DW'(r_pms) : DW'(r_pu);
                            mul_start    = 1'b1;
                            mul_a        = r_tick;
                            mul_b        = MUL_W'(r_held_ms);
                            n_state      = ST_QRY_W;
                        end
                    endcase
                end
            end
            ST_CFG_FK: begin
                if (!div_busy) begin
                    n_fk         = div_quo[FK_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = DW'(r_freq);
                    div_divisor  = DW'(MEGA);
                    n_state      = ST_CFG_PU;
                end
            end
            ST_CFG_PU: begin
                if (!div_busy) begin
                    n_pu      = pu_q;
                    mul_start = 1'b1;
                    mul_a     = MUL_W'(KILO);
                    mul_b     = MUL_W'(pu_q);
                    n_state   = ST_CFG_PMS;
                end
            end
            ST_CFG_PMS: begin
                if (!mul_busy) begin
                    n_pms   = mul_prod[PMS_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            ST_START_W: begin
                if (!mul_busy) begin
                    n_held                = mul_lo;
                    n_held_ms             = r_interval;
                    n_deadline            = st_dl;
                    n_running             = 1'b1;
                    n_res                 = '0;
                    n_res.compare_value   = CMP_W'(st_dl);
                    n_res.write_compare   = 1'b1;
                    n_res.counter_enabled = 1'b1;
                    n_state               = ST_DONE;
                end
            end
            ST_SV_PREP: begin
                // Count this tick and advance by one interval
                n_tick     = r_tick + MUL_W'(1);
                n_deadline = sv_nd;
                n_d        = sv_d;
                n_state    = ST_SV_CHK;
            end
            ST_SV_CHK: begin
                if (sv_ahead && (r_held != '0)) begin
                    // Late: count the missed intervals in one division
                    div_start = 1'b1;
                    if (sv_short) begin
                        div_dividend = DW'(sv_fwd);
                        div_divisor  = DW'(r_held);
                    end else begin
                        div_dividend = DW'(sv_rev);
                        div_divisor  = DW'(sv_back);
                    end
                    n_state = ST_SV_DIV;
                end else begin
                    n_res                 = '0;
                    n_res.compare_value   = CMP_W'(r_deadline);
                    n_res.write_compare   = 1'b1;
                    n_res.notify          = 1'b1;
                    n_res.counter_enabled = 1'b1;
                    n_state               = ST_DONE;
                end
            end
            ST_SV_DIV: begin
                if (!div_busy) begin
                    n_extra   = sv_extra;
                    mul_start = 1'b1;
                    mul_a     = MUL_W'(r_held);
                    mul_b     = MUL_W'(sv_extra);
                    n_state   = ST_SV_MUL;
                end
            end
            ST_SV_MUL: begin
                if (!mul_busy) begin
                    n_deadline            = sv_dl;
                    n_tick                = r_tick + MUL_W'(r_extra);
                    n_res                 = '0;
                    n_res.compare_value   = CMP_W'(sv_dl);
                    n_res.write_compare   = 1'b1;
                    n_res.notify          = 1'b1;
                    n_res.counter_enabled = 1'b1;
                    n_state               = ST_DONE;
                end
            end
            ST_QRY_W: begin
                if (!div_busy && !mul_busy) begin
                    if (r_cmd == CMD_QRY_MS) begin
                        n_res                 = '0;
                        n_res.counter_enabled = r_running;
                        n_res.time_value      = {{(TIME_W - CMP_W){1'b0}}, prod_sum[CMP_W-1:0]};
                        n_state               = ST_DONE;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = mul_prod;
                        mul_b     = MUL_W'(KILO);
                        n_state   = ST_QRY_US;
                    end
                end
            end
            ST_QRY_US: begin
                if (!mul_busy) begin
                    n_res                 = '0;
                    n_res.counter_enabled = r_running;
                    n_res.time_value      = prod_sum;
                    n_state               = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold the result until the output register frees up
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Register writes; a new frequency restarts the ratio update
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_FREQ: begin
                    n_freq       = i_cfg_wdata;
                    div_start    = 1'b1;
                    div_dividend = DW'(i_cfg_wdata);
                    div_divisor  = DW'(KILO);
                    n_state      = ST_CFG_FK;
                end
                REG_INTERVAL: begin
                    n_interval = i_cfg_wdata[IVL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Timer state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq      <= FREQ_W'(FREQ_RST);
            r_interval  <= IVL_W'(IVL_RST);
            r_fk        <= FK_W'(FK_RST);
            r_pu        <= PU_W'(PU_RST);
            r_pms       <= PMS_W'(PMS_RST);
            r_tick      <= '0;
            r_deadline  <= '0;
            r_running   <= 1'b0;
            r_held      <= '0;
            r_held_ms   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_freq      <= n_freq;
            r_interval  <= n_interval;
            r_fk        <= n_fk;
            r_pu        <= n_pu;
            r_pms       <= n_pms;
            r_tick      <= n_tick;
            r_deadline  <= n_deadline;
            r_running   <= n_running;
            r_held      <= n_held;
            r_held_ms   <= n_held_ms;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_now   <= n_now;
        r_d     <= n_d;
        r_extra <= n_extra;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.compare_value   = r_out.compare_value;
    assign o_out.write_compare   = r_out.write_compare;
    assign o_out.notify          = r_out.notify;
    assign o_out.counter_enabled = r_out.counter_enabled;
    assign o_out.time_value      = r_out.time_value;

endmodule

### rtl/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the tick timer, bound to the top level.
// ----------------------------------------------------------------------------
module ptt_checker
    import ptt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CMP_W-1:0]  i_compare_value,
    input logic              i_write_compare,
    input logic              i_notify,
    input logic              i_counter_enabled,
    input logic [TIME_W-1:0] i_time_value
);
    logic r_seen_en;

    // Remember that an enabled result has gone out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_en <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_counter_enabled) begin
            r_seen_en <= 1'b1;
        end
    end

    // One item at a time: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after an item was accepted");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_compare_value)
            && $stable(i_write_compare) && $stable(i_notify)
            && $stable(i_counter_enabled) && $stable(i_time_value))
        else $error("stalled result changed");

    // A compare write comes only with the counter on and no time value
    a_wr_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_write_compare |-> i_counter_enabled && (i_time_value == '0))
        else $error("compare write without enabled counter or with a time value");

    // Notify comes only with a compare write
    a_notify_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_notify |-> i_write_compare)
        else $error("notify without compare write");

    // Once enabled, the counter stays enabled
    a_en_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_en |-> i_counter_enabled)
        else $error("counter_enabled fell after start");

endmodule

bind periodic_compare_tick_timer_top ptt_checker u_ptt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_compare_value   (o_out.compare_value),
    .i_write_compare   (o_out.write_compare),
    .i_notify          (o_out.notify),
    .i_counter_enabled (o_out.counter_enabled),
    .i_time_value      (o_out.time_value)
);

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic compare tick timer. It drives start,
// service and time query items over the command channel and mirrors the
// timer state (tick total, next deadline, latched interval) in a local
// predictor. Every result item is compared field by field against the
// predicted one. Stimulus starts with directed corner cases (reset state,
// deadline wrap, late service, zero and over-half intervals, a slow count
// clock) and continues with deadline-aware random traffic over several
// register settings and three handshake idling profiles.
// ----------------------------------------------------------------------------
module tb
    import ptt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CNT_W       = 32;
    localparam int          STALL_LIMIT = 5000;
    localparam int          CFG_SETTLE  = 150;
    localparam int          END_SETTLE  = 64;
    localparam int          PASS_ITEMS  = 180;
    localparam int          MAX_REPORTS = 10;
    localparam logic [63:0] PER_KILO    = 64'd1000;
    localparam logic [63:0] PER_MEGA    = 64'd1000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [FREQ_W-1:0] i_cfg_wdata;

    ptt_in_if  cmd_bus ();
    ptt_out_if res_bus ();

    periodic_compare_tick_timer_top #(
        .COUNT_WIDTH (CNT_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (cmd_bus),
        .o_out       (res_bus)
    );

    // Mirrored timer state and register copies
    logic [FREQ_W-1:0] cfg_freq_hz;
    logic [IVL_W-1:0]  cfg_interval_ms;
    logic [63:0]       mdl_ticks;
    logic [31:0]       mdl_deadline;
    logic              mdl_running;
    logic [31:0]       mdl_step_counts;
    logic [IVL_W-1:0]  mdl_step_ms;

    t_result pending_results[$];

    int src_idle_pct;
    int snk_idle_pct;
    int fail_count;
    int stall_cycles;
    int n_items;
    int n_starts;
    int n_services;
    int n_queries;
    int n_results;
    int n_settings;

    // Toggle the clock
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Count one tick plus every interval missed since the deadline
    function automatic void advance_ticks(logic [31:0] now);
        logic [31:0] step;
        logic [31:0] gap;
        logic [63:0] extra;
        logic [63:0] back;
        logic [63:0] prod;
        step  = mdl_step_counts;
        extra = 64'd0;
        mdl_ticks    = mdl_ticks + 64'd1;
        mdl_deadline = mdl_deadline + step;
        gap = now - mdl_deadline;
        // deadline still behind the count: close the gap in one go
        if (gap != 32'd0 && !gap[CNT_W-1] && step != 32'd0) begin
            if (step <= 32'h8000_0000) begin
                extra = (64'(gap) - 64'd1) / 64'(step) + 64'd1;
            end else begin
                back  = 64'h1_0000_0000 - 64'(step);
                extra = (64'h8000_0000 - 64'(gap) - 64'd1) / back + 64'd1;
            end
        end
        mdl_ticks    = mdl_ticks + extra;
        prod         = extra * 64'(step);
        mdl_deadline = mdl_deadline + prod[31:0];
    endfunction

    // Work out the result of one item and update the mirrored state
    function automatic t_result predict_timer(t_cmd cmd, logic [31:0] now);
        t_result     res;
        logic [63:0] wide;
        logic [31:0] elapsed;
        logic [63:0] per_us;
        logic [63:0] tv;
        res = '0;
        case (cmd)
            CMD_START: begin
                mdl_step_ms     = cfg_interval_ms;
                wide            = 64'(cfg_interval_ms) * (64'(cfg_freq_hz) / PER_KILO);
                mdl_step_counts = wide[31:0];
                mdl_deadline    = now + mdl_step_counts;
                mdl_running     = 1'b1;
                res.compare_value = mdl_deadline;
                res.write_compare = 1'b1;
            end
            CMD_SERVICE: begin
                if (mdl_running) begin
                    advance_ticks(now);
                    res.compare_value = mdl_deadline;
                    res.write_compare = 1'b1;
                    res.notify        = 1'b1;
                end
            end
            default: begin
                elapsed = now - mdl_deadline + mdl_step_counts;
                per_us  = 64'(cfg_freq_hz) / PER_MEGA;
                if (per_us == 64'd0) begin
                    per_us = 64'd1;
                end
                if (cmd == CMD_QRY_MS) begin
                    tv = mdl_ticks * 64'(mdl_step_ms) + 64'(elapsed) / (per_us * PER_KILO);
                    tv[63:32] = 32'd0;
                end else begin
                    tv = mdl_ticks * 64'(mdl_step_ms) * PER_KILO + 64'(elapsed) / per_us;
                end
                res.time_value = tv;
            end
        endcase
        res.counter_enabled = mdl_running;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Hold ready low at random per the receiver idling profile
    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Send one item, predict its result once it is accepted
    task automatic send_item(t_cmd cmd, logic [31:0] sample);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.command      <= cmd;
        cmd_bus.count_sample <= sample;
        @(posedge i_clk);
        while (!cmd_bus.ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(predict_timer(cmd, sample));
        n_items++;
        case (cmd)
            CMD_START:   n_starts++;
            CMD_SERVICE: n_services++;
            default:     n_queries++;
        endcase
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write one register once the block has settled
    task automatic write_reg(t_cfg_reg idx, logic [FREQ_W-1:0] value);
        repeat (CFG_SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        if (idx == REG_FREQ) begin
            cfg_freq_hz = value;
        end else begin
            cfg_interval_ms = value[IVL_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [FREQ_W-1:0] freq, logic [FREQ_W-1:0] ivl_word);
        drain_results();
        write_reg(REG_FREQ, freq);
        write_reg(REG_INTERVAL, ivl_word);
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("mismatch on result %0d, %0s: expected %h, got %h",
                         n_results, name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("result item with nothing expected: compare %h time %h",
                             res_bus.compare_value, res_bus.time_value);
                end
            end else begin
                want = pending_results.pop_front();
                check_field("compare_value", 64'(want.compare_value),
                            64'(res_bus.compare_value));
                check_field("write_compare", 64'(want.write_compare),
                            64'(res_bus.write_compare));
                check_field("notify", 64'(want.notify), 64'(res_bus.notify));
                check_field("counter_enabled", 64'(want.counter_enabled),
                            64'(res_bus.counter_enabled));
                check_field("time_value", want.time_value, res_bus.time_value);
            end
            n_results++;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: queries and service before start, deadline wrap,
    // on-time, early, late and far-off services
    task automatic test_reset_defaults();
        send_item(CMD_QRY_MS, 32'h0000_0000);
        send_item(CMD_QRY_US, 32'hFFFF_FFFF);
        send_item(CMD_SERVICE, 32'h0000_1234);
        send_item(CMD_START, 32'hFFFF_0000);
        send_item(CMD_SERVICE, mdl_deadline);
        send_item(CMD_QRY_MS, mdl_deadline + 32'd500);
        send_item(CMD_QRY_US, mdl_deadline + 32'd500);
        send_item(CMD_SERVICE, mdl_deadline - 32'd5);
        send_item(CMD_SERVICE, mdl_deadline + 5 * mdl_step_counts + 32'd17);
        send_item(CMD_QRY_US, mdl_deadline);
        send_item(CMD_SERVICE, mdl_deadline + 32'h8000_0010);
    endtask

    // Interval that wraps to zero counts: service must not spin
    task automatic test_zero_interval();
        set_config(30'd131072000, 30'd32768);
        send_item(CMD_START, 32'h0000_0000);
        send_item(CMD_SERVICE, 32'h0000_0005);
        send_item(CMD_SERVICE, 32'hFFFF_FFFF);
        send_item(CMD_QRY_MS, 32'h7FFF_FFFF);
        send_item(CMD_QRY_US, 32'h8000_0000);
    endtask

    // Interval above half the count range
    task automatic test_wide_interval();
        set_config(30'd100000000, 30'd30000);
        send_item(CMD_START, 32'h0000_0010);
        send_item(CMD_SERVICE, mdl_deadline + 32'd100);
        send_item(CMD_SERVICE, 32'h5A5A_A5A5);
        send_item(CMD_QRY_MS, 32'hC000_0000);
    endtask

    // Count clock below one MHz
    task automatic test_slow_clock();
        set_config(30'd500000, 30'd3);
        send_item(CMD_START, 32'h0000_0100);
        send_item(CMD_SERVICE, mdl_deadline + 3 * mdl_step_counts + 32'd7);
        send_item(CMD_QRY_US, mdl_deadline + 32'd40);
        send_item(CMD_QRY_MS, mdl_deadline + 32'd40);
    endtask

    // Random traffic aimed around the current deadline
    task automatic run_random(int count);
        int          r;
        int          m;
        logic [31:0] off;
        logic [31:0] step;
        for (int i = 0; i < count; i++) begin
            r    = $urandom_range(99);
            m    = $urandom_range(9);
            step = mdl_step_counts;
            off  = (step == 32'd0) ? 32'd0 : $urandom_range(step - 32'd1, 0);
            // pause the sender once until the block is empty
            if (i == count / 2) begin
                drain_results();
            end
            if (!mdl_running || r < 4) begin
                send_item(CMD_START, $urandom());
            end else if (r < 50) begin
                if (m < 5) begin
                    send_item(CMD_SERVICE, mdl_deadline + $urandom_range(4095));
                end else if (m < 8) begin
                    send_item(CMD_SERVICE,
                              mdl_deadline + $urandom_range(8, 1) * step + off);
                end else if (m == 8) begin
                    send_item(CMD_SERVICE, mdl_deadline - $urandom_range(1000, 1));
                end else begin
                    send_item(CMD_SERVICE, $urandom());
                end
            end else if (r < 94) begin
                if (m < 8) begin
                    off = (step == 32'd0) ? $urandom_range(100000) : off;
                    send_item((r < 72) ? CMD_QRY_MS : CMD_QRY_US,
                              mdl_deadline - step + off);
                end else begin
                    send_item((r < 72) ? CMD_QRY_MS : CMD_QRY_US, $urandom());
                end
            end else begin
                send_item(t_cmd'($urandom_range(3)), $urandom());
            end
        end
    endtask

    // Three register settings per idling profile, extremes among them
    task automatic test_random_traffic(int src_pct, int snk_pct, int profile);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int k = 0; k < 3; k++) begin
            case (profile * 3 + k)
                0: set_config(30'd1000000, 30'd1);
                1: set_config(30'($urandom_range(1000000000, 1000000)),
                              {14'($urandom()), 16'($urandom_range(65535, 1))});
                2: set_config(30'd1000000000, 30'd65535);
                3: set_config(30'd100000000, 30'd30000);
                4: set_config(30'($urandom_range(1000000000, 1000000)),
                              {14'($urandom()), 16'($urandom_range(65535, 1))});
                5: set_config(30'd999999, {14'h3FFF, 16'd123});
                6: set_config(30'd131072000, 30'd32768);
                7: set_config(30'h3FFF_FFFF, 30'h3FFF_FFFF);
                default: set_config(30'($urandom_range(1000000000, 1000000)),
                                    30'($urandom_range(65535, 1)));
            endcase
            run_random(PASS_ITEMS);
        end
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = REG_FREQ;
        i_cfg_wdata          = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.command      = CMD_START;
        cmd_bus.count_sample = '0;
        res_bus.ready        = 1'b0;
        src_idle_pct         = 17;
        snk_idle_pct         = 58;
        fail_count           = 0;
        stall_cycles         = 0;
        n_items              = 0;
        n_starts             = 0;
        n_services           = 0;
        n_queries            = 0;
        n_results            = 0;
        n_settings           = 1;
        cfg_freq_hz          = FREQ_W'(FREQ_RST);
        cfg_interval_ms      = IVL_W'(IVL_RST);
        mdl_ticks            = '0;
        mdl_deadline         = '0;
        mdl_running          = 1'b0;
        mdl_step_counts      = '0;
        mdl_step_ms          = '0;

        // hold reset, then release it on a falling clock edge
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_interval();
        test_wide_interval();
        test_slow_clock();
        test_random_traffic(17, 58, 0);
        test_random_traffic(58, 17, 1);
        test_random_traffic(0, 0, 2);

        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("covered %0d items: %0d starts, %0d services, %0d queries",
                 n_items, n_starts, n_services, n_queries);
        $display("checked %0d results over %0d register settings, %0d mismatches",
                 n_results, n_settings, fail_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
